// ===== rtl/core/gift_pkg.sv =====
// ----------------------------------------------------------------------------
// GIFT-128 shared definitions
// S-box, bit permutation map, widths and the cell control bundle.
// ----------------------------------------------------------------------------
package gift_pkg;

	localparam int BLOCK_W  = 128;
	localparam int NIB_CNT  = 32;
	localparam int KWORD_W  = 16;
	localparam int KWORD_CNT = 8;
	localparam int RND_W    = 6;
	localparam int LFSR_W   = 6;
	localparam int PADDR_W  = 3;

	localparam logic [RND_W-1:0] ROUND_COUNT_RST = 6'd40;
	localparam logic REG_ROUND_COUNT = 1'b0;

	localparam logic [3:0] SBOX [16] = '{
		4'd1, 4'd10, 4'd4, 4'd12, 4'd6, 4'd15, 4'd3, 4'd9,
		4'd2, 4'd13, 4'd11, 4'd7, 4'd5, 4'd0, 4'd8, 4'd14
	};

	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

	function automatic logic [6:0] perm_pos(input logic [6:0] i);
		logic [1:0] grp;
		logic [1:0] lane;
		logic [1:0] sel;
		begin
			grp  = i[3:2];
			lane = i[1:0];
			sel  = 2'(3 * grp + lane);
			perm_pos = {sel, i[6:4], lane};
		end
	endfunction

endpackage

// ===== rtl/core/gift_nib_cell.sv =====
// ----------------------------------------------------------------------------
// GIFT-128 state nibble cell
// Holds one nibble of the cipher state and presents its S-box image.
// ----------------------------------------------------------------------------
module gift_nib_cell
	import gift_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic [3:0] load_nib,
	input  logic [3:0] next_nib,
	output logic [3:0] nib,
	output logic [3:0] sub_nib
);

	logic [3:0] nib_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			nib_q <= load_nib;
		end else if (ctrl.step) begin
			nib_q <= next_nib;
		end
	end

	assign nib     = nib_q;
	assign sub_nib = SBOX[nib_q];

endmodule

// ===== rtl/core/gift_key_cell.sv =====
// ----------------------------------------------------------------------------
// GIFT-128 key word cell
// Holds one 16-bit key word; takes the word two places up on each round.
// ----------------------------------------------------------------------------
module gift_key_cell
	import gift_pkg::*;
#(
	parameter int ROT = 0
) (
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic [KWORD_W-1:0] load_word,
	input  logic [KWORD_W-1:0] nbr_word,
	output logic [KWORD_W-1:0] word
);

	logic [KWORD_W-1:0] word_q;
	logic [KWORD_W-1:0] rot_word;

	assign rot_word = (nbr_word >> ROT) | (nbr_word << (KWORD_W - ROT));

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			word_q <= load_word;
		end else if (ctrl.step) begin
			word_q <= rot_word;
		end
	end

	assign word = word_q;

endmodule

// ===== rtl/core/gift128_block_encrypt_unit.sv =====
// ----------------------------------------------------------------------------
// GIFT-128 block encryption unit
// An input transaction loads the cells; the result is registered after the
// last round. One round per cycle through the row of 32 nibble cells and
// 8 key word cells; a new block can be taken as the last one finishes.
// The input is taken while a finished result still waits at the output.
// Reset: asynchronous, active low; round_count returns to 40, block idle.
// ----------------------------------------------------------------------------
module gift128_block_encrypt_unit
	import gift_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// s_tdata: text_lo[63:0], text_hi[127:64], key_lo[191:128], key_hi[255:192]
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [255:0]       s_tdata,
	// m_tdata: cipher_lo[63:0], cipher_hi[127:64]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [127:0]       m_tdata,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [RND_W-1:0]   round_count_q;
	logic               busy_q;
	logic [RND_W-1:0]   cnt_q;
	logic [LFSR_W-1:0]  lfsr_q;
	logic               out_valid_q;
	logic [BLOCK_W-1:0] out_data_q;

	logic               accept;
	logic               fin;
	logic               step;
	cell_ctrl_t         ctrl;
	logic [LFSR_W-1:0]  lfsr_nxt;

	logic [BLOCK_W-1:0] state_all;
	logic [BLOCK_W-1:0] sub_all;
	logic [BLOCK_W-1:0] perm_all;
	logic [BLOCK_W-1:0] rc_mask;
	logic [BLOCK_W-1:0] key_mask;
	logic [BLOCK_W-1:0] next_all;
	logic [BLOCK_W-1:0] key_all;
	logic [KWORD_W-1:0] kword [KWORD_CNT];

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= ROUND_COUNT_RST;
		end else if (psel && penable && pwrite && pready
			&& (paddr[2] == REG_ROUND_COUNT)) begin
			round_count_q <= pwdata[RND_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_ROUND_COUNT) begin
			prdata = {{(32-RND_W){1'b0}}, round_count_q};
		end
	end

	// control
	assign fin      = busy_q && (cnt_q == '0) && (!out_valid_q || m_tready);
	assign s_tready = !busy_q || fin;
	assign accept   = s_tvalid && s_tready;
	assign step     = busy_q && (cnt_q != '0);
	assign ctrl.load = accept;
	assign ctrl.step = step;
	assign lfsr_nxt = {lfsr_q[LFSR_W-2:0], lfsr_q[5] ^ lfsr_q[4] ^ 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			lfsr_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= round_count_q;
				lfsr_q <= '0;
			end else begin
				if (fin) begin
					busy_q <= 1'b0;
				end
				if (step) begin
					cnt_q  <= cnt_q - 1'b1;
					lfsr_q <= lfsr_nxt;
				end
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_data_q <= state_all;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// state row
	genvar gi;
	generate
		for (gi = 0; gi < NIB_CNT; gi++) begin : g_nib
			gift_nib_cell u_nib (
				.clk      (clk),
				.ctrl     (ctrl),
				.load_nib (s_tdata[4*gi +: 4]),
				.next_nib (next_all[4*gi +: 4]),
				.nib      (state_all[4*gi +: 4]),
				.sub_nib  (sub_all[4*gi +: 4])
			);
		end

		for (gi = 0; gi < BLOCK_W; gi++) begin : g_perm
			localparam logic [6:0] DST = perm_pos(7'(gi));
			assign perm_all[DST] = sub_all[gi];
		end

		for (gi = 0; gi < NIB_CNT; gi++) begin : g_mask
			if (gi < LFSR_W) begin : g_rc
				assign rc_mask[4*gi+3] = lfsr_nxt[gi];
			end else if (gi == NIB_CNT - 1) begin : g_top
				assign rc_mask[4*gi+3] = 1'b1;
			end else begin : g_none
				assign rc_mask[4*gi+3] = 1'b0;
			end
			assign rc_mask[4*gi+2 -: 3] = 3'b000;
			assign key_mask[4*gi]   = 1'b0;
			assign key_mask[4*gi+1] = key_all[gi];
			assign key_mask[4*gi+2] = key_all[64+gi];
			assign key_mask[4*gi+3] = 1'b0;
		end

		// key row: each word takes the one two places up, the wrap rotates
		for (gi = 0; gi < KWORD_CNT; gi++) begin : g_key
			localparam int SRC = (gi + 2) % KWORD_CNT;
			localparam int ROT = (gi == 6) ? 12 : ((gi == 7) ? 2 : 0);
			gift_key_cell #(
				.ROT (ROT)
			) u_key (
				.clk       (clk),
				.ctrl      (ctrl),
				.load_word (s_tdata[BLOCK_W + KWORD_W*gi +: KWORD_W]),
				.nbr_word  (kword[SRC]),
				.word      (kword[gi])
			);
			assign key_all[KWORD_W*gi +: KWORD_W] = kword[gi];
		end
	endgenerate

	assign next_all = perm_all ^ rc_mask ^ key_mask;

endmodule
